// ===== rtl/core/sld_pkg.sv =====
// ----------------------------------------------------------------------------
// sld_pkg
// Types and constants shared by the sync word and length frame receiver.
// ----------------------------------------------------------------------------
package sld_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned SYNC_W  = 32;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned RSP_W   = 40;

   localparam logic [SYNC_W-1:0] SYNC_RESET = 32'hBEBA_BEEF;

   typedef enum logic [2:0] {
      PH_SYNC0   = 3'd0,
      PH_SYNC1   = 3'd1,
      PH_SYNC2   = 3'd2,
      PH_SYNC3   = 3'd3,
      PH_LEN_HI  = 3'd4,
      PH_LEN_LO  = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_SPARE   = 3'd7
   } phase_type;

   typedef struct packed {
      logic              payload_valid;
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  payload_index;
      logic              frame_done;
      logic [LEN_W-1:0]  frame_length;
   } result_type;

endpackage

// ===== rtl/core/sync_length_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_length_deframer
// Hunts for a four-byte sync word, reads a big-endian 16-bit length and
// streams the payload bytes out with their index, one result per byte.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while the result side is ready; the frame state updates in the single pass
// between the two registers, so back-to-back bytes need no stall.
// Reset: synchronous, active high; clears the phase, counters and pipeline
// valids, and loads the sync word register with 0xBEBABEEF.
module sync_length_deframer
   import sld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Received byte stream.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] rx_byte
   // Results, one per received byte.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                          // [39:24] frame_length
   output logic              rsp_tuser,   // [0] payload_valid
   output logic              rsp_tlast,   // frame_done
   // Sync word register write.
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SYNC_W-1:0] csr_data
);

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff;
   result_type        out_ff;
   result_type        res_in;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [SYNC_W-1:0] sync_ff;

   logic              advance;
   logic [BYTE_W-1:0] expect_byte;
   logic              sync_hit;
   logic [LEN_W-1:0]  len_full;
   logic [LEN_W-1:0]  count_inc;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
      end else if (csr_valid) begin
         sync_ff <= csr_data;
      end
   end

   // Sync byte expected in the current hunting phase; the spare code hunts
   // for the first byte.
   always_comb begin
      case (phase_ff)
         PH_SYNC1: expect_byte = sync_ff[23:16];
         PH_SYNC2: expect_byte = sync_ff[15:8];
         PH_SYNC3: expect_byte = sync_ff[7:0];
         default:  expect_byte = sync_ff[31:24];
      endcase
   end

   assign sync_hit  = (expect_byte == in_byte_ff);
   assign len_full  = {length_ff[LEN_W-1:BYTE_W], in_byte_ff};
   assign count_inc = count_ff + 1'b1;

   // Next state.
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      case (phase_ff)
         PH_SYNC0: phase_in = sync_hit ? PH_SYNC1 : PH_SYNC0;
         PH_SYNC1: phase_in = sync_hit ? PH_SYNC2 : PH_SYNC0;
         PH_SYNC2: phase_in = sync_hit ? PH_SYNC3 : PH_SYNC0;
         PH_SYNC3: phase_in = sync_hit ? PH_LEN_HI : PH_SYNC0;
         PH_LEN_HI: begin
            length_in = {in_byte_ff, {BYTE_W{1'b0}}};
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = len_full;
            count_in  = '0;
            phase_in  = (len_full == '0) ? PH_SYNC0 : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            count_in = count_inc;
            phase_in = (count_inc == length_ff) ? PH_SYNC0 : PH_PAYLOAD;
         end
         default: phase_in = sync_hit ? PH_SYNC1 : PH_SYNC0;
      endcase
   end

   // Result for the byte in the input register.
   always_comb begin
      res_in = '0;
      case (phase_ff)
         PH_LEN_LO: begin
            res_in.frame_length = len_full;
            res_in.frame_done   = (len_full == '0);
         end
         PH_PAYLOAD: begin
            res_in.payload_valid = 1'b1;
            res_in.payload_byte  = in_byte_ff;
            res_in.payload_index = count_ff;
            res_in.frame_length  = length_ff;
            res_in.frame_done    = (count_inc == length_ff);
         end
         default: res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC0;
         count_ff  <= '0;
         length_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.frame_length, out_ff.payload_index, out_ff.payload_byte};
   assign rsp_tuser  = out_ff.payload_valid;
   assign rsp_tlast  = out_ff.frame_done;

`ifndef NO_ASSERTIONS
   // While receiving payload, the count never reaches the announced length.
   a_count_below_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> count_ff < length_ff)
      else $error("payload count reached announced length");

   // The last payload byte of a frame carries index length minus one.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tlast |->
         out_ff.payload_index == out_ff.frame_length - 1'b1)
      else $error("frame ended at wrong payload index");

   // Non-payload results carry neither a byte nor an index.
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         out_ff.payload_byte == '0 && out_ff.payload_index == '0)
      else $error("non-payload result carries payload fields");

   // Frame state moves only when a byte passes to the result register.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(count_ff) && $stable(length_ff))
      else $error("frame state changed without a byte");
`endif

endmodule

// ===== bench/sync_length_deframer_test.sv =====
// ----------------------------------------------------------------------------
// sync_length_deframer_test
// Self-checking bench for the sync word and length frame receiver. A
// scoreboard predicts one result word per received byte and compares every
// result field by field. The stimulus is a short directed opening, random
// frame traffic under three idle patterns and several sync word settings,
// and the opening stretch of a frame of the largest length.
// ----------------------------------------------------------------------------
module sync_length_deframer_test
   import sld_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES    = 80;
   localparam int unsigned SETTLE_CYCLES  = 4;

   class frame_scoreboard;
      logic [SYNC_W-1:0] sync_word;
      phase_type         phase;
      logic [LEN_W-1:0]  rx_count;
      logic [LEN_W-1:0]  rx_length;
      result_type        expected_q[$];
      int unsigned       mismatches;
      int unsigned       frames_done;
      int unsigned       payload_words;

      function new();
         sync_word     = SYNC_RESET;
         phase         = PH_SYNC0;
         rx_count      = '0;
         rx_length     = '0;
         mismatches    = 0;
         frames_done   = 0;
         payload_words = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Advances the frame state by one received byte and queues its result.
      function void note_input(logic [BYTE_W-1:0] rx);
         result_type        r;
         logic [BYTE_W-1:0] want;
         int                shift;
         r = '0;
         case (phase)
            PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3: begin
               shift = 8 * (3 - int'(phase));
               want  = BYTE_W'(sync_word >> shift);
               // A wrong byte restarts the hunt without being retried as byte 0.
               phase = (want == rx) ? phase_type'(phase + 3'd1) : PH_SYNC0;
            end
            PH_LEN_HI: begin
               rx_length = {rx, 8'h00};
               phase     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               rx_length[7:0] = rx;
               rx_count       = '0;
               r.frame_length = rx_length;
               if (rx_length == '0) begin
                  r.frame_done = 1'b1;
                  phase        = PH_SYNC0;
               end else begin
                  phase = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               r.payload_valid = 1'b1;
               r.payload_byte  = rx;
               r.payload_index = rx_count;
               r.frame_length  = rx_length;
               rx_count        = rx_count + 1'b1;
               if (rx_count == rx_length) begin
                  r.frame_done = 1'b1;
                  phase        = PH_SYNC0;
               end
            end
            default: begin
               phase = (rx == sync_word[31:24]) ? PH_SYNC1 : PH_SYNC0;
            end
         endcase
         expected_q.push_back(r);
      endfunction

      task report(string what, logic [RSP_W+1:0] got_v, logic [RSP_W+1:0] exp_v);
         $display("%0t: MISMATCH %s: got %0h, expected %0h", $realtime, what, got_v, exp_v);
         mismatches++;
      endtask

      task check_result(result_type got);
         result_type exp;
         if (expected_q.size() == 0) begin
            report("result with nothing expected", got, '0);
            return;
         end
         exp = expected_q.pop_front();
         if (got.payload_valid !== exp.payload_valid)
            report("payload_valid", got.payload_valid, exp.payload_valid);
         if (got.payload_byte !== exp.payload_byte)
            report("payload_byte", got.payload_byte, exp.payload_byte);
         if (got.payload_index !== exp.payload_index)
            report("payload_index", got.payload_index, exp.payload_index);
         if (got.frame_done !== exp.frame_done)
            report("frame_done", got.frame_done, exp.frame_done);
         if (got.frame_length !== exp.frame_length)
            report("frame_length", got.frame_length, exp.frame_length);
         if (exp.frame_done)
            frames_done++;
         if (exp.payload_valid)
            payload_words++;
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;
   logic              csr_valid;
   logic              csr_ready;
   logic [SYNC_W-1:0] csr_data;

   frame_scoreboard   sb;
   logic [SYNC_W-1:0] cur_sync;
   int unsigned       items_sent;
   int unsigned       sync_writes;
   int unsigned       req_idle_pct;
   int unsigned       rsp_idle_pct;
   int unsigned       quiet_cycles;
   logic              hold_toggle;

   sync_length_deframer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Result receiver: random back-pressure, plus a long hold-off on request.
   always @(posedge clock) begin : receiver
      int unsigned hold_left;
      logic        seen_toggle;
      if (reset) begin
         hold_left   = 0;
         seen_toggle = hold_toggle;
         rsp_tready <= 1'b0;
      end else begin
         if (seen_toggle != hold_toggle) begin
            seen_toggle = hold_toggle;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Samples every handshake at the edge where it completes.
   always @(posedge clock) begin : monitor
      result_type got;
      logic       moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.payload_valid = rsp_tuser;
            got.payload_byte  = rsp_tdata[7:0];
            got.payload_index = rsp_tdata[23:8];
            got.frame_done    = rsp_tlast;
            got.frame_length  = rsp_tdata[39:24];
            sb.check_result(got);
            moved = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            sb.note_input(req_tdata);
            moved = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            sb.sync_word = csr_data;
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("sync_length_deframer_test NOT OK");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [BYTE_W-1:0] rx);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_frame(input logic [LEN_W-1:0] len);
      for (int i = 0; i < 4; i++)
         send_word(cur_sync[31 - 8*i -: 8]);
      send_word(len[15:8]);
      send_word(len[7:0]);
      repeat (len) send_word(BYTE_W'($urandom_range(255)));
   endtask

   // Stops sending and waits until every queued result has been taken. The
   // first edge lets the monitor note a word accepted at the previous edge.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sync(input logic [SYNC_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_sync = value;
      sync_writes++;
      repeat (2) @(posedge clock);
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned       stop_at;
      int unsigned       pick;
      int unsigned       k;
      logic [BYTE_W-1:0] rx;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            if ($urandom_range(9) < 8) send_frame(LEN_W'($urandom_range(12)));
            else send_frame(LEN_W'($urandom_range(300, 13)));
         end else if (pick < 88) begin
            repeat ($urandom_range(6, 1)) send_word(BYTE_W'($urandom_range(255)));
         end else begin
            // A sync prefix that breaks off with a wrong byte.
            k = $urandom_range(3, 1);
            for (int i = 0; i < k; i++)
               send_word(cur_sync[31 - 8*i -: 8]);
            rx = BYTE_W'($urandom_range(255));
            if (rx == cur_sync[31 - 8*k -: 8])
               rx ^= 8'h01;
            send_word(rx);
         end
      end
   endtask

   initial begin : stimulus
      // Noise at both extremes, an empty frame, a second sync byte that must
      // not restart the hunt, and a short frame with extreme payload bytes.
      logic [BYTE_W-1:0] opening [21] = '{
         8'h00, 8'hFF,
         8'hBE, 8'hBA, 8'hBE, 8'hEF, 8'h00, 8'h00,
         8'hBE, 8'hBE, 8'hBA, 8'hBE, 8'hEF,
         8'hBE, 8'hBA, 8'hBE, 8'hEF, 8'h00, 8'h02, 8'hFF, 8'h00};
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      hold_toggle  = 1'b0;
      quiet_cycles = 0;
      items_sent   = 0;
      sync_writes  = 0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      cur_sync     = SYNC_RESET;
      sb           = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) send_word(opening[i]);

      // Sender mostly busy, receiver mostly stalled.
      write_sync(32'hFFFF_FFFF);
      req_idle_pct = 8;
      rsp_idle_pct = 82;
      run_random(380);

      // Sender mostly idle, receiver mostly ready, with a full drain midway.
      write_sync(32'h0000_0000);
      req_idle_pct = 82;
      rsp_idle_pct = 8;
      run_random(180);
      drain();
      run_random(180);

      // No idling, except one long receiver hold-off that backs up the input.
      write_sync(SYNC_W'($urandom));
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_toggle <= ~hold_toggle;
      run_random(380);

      // Header of the largest frame, followed by only its first payload bytes.
      write_sync(SYNC_RESET);
      for (int i = 0; i < 4; i++)
         send_word(cur_sync[31 - 8*i -: 8]);
      send_word(8'hFF);
      send_word(8'hFF);
      repeat (80) send_word(BYTE_W'($urandom_range(255)));

      drain();
      repeat (8) @(posedge clock);
      while (sb.pending() != 0) begin
         sb.report("result never arrived", '0, sb.expected_q.pop_front());
      end
      $display("Sent %0d input words under %0d sync word settings and three idle patterns.",
               items_sent, sync_writes + 1);
      $display("Checked %0d completed frames and %0d payload words, plus the start of a %s",
               sb.frames_done, sb.payload_words, "frame announcing length 65535.");
      if (sb.mismatches == 0) begin
         $display("sync_length_deframer_test OK");
      end else begin
         $display("sync_length_deframer_test NOT OK");
      end
      $finish;
   end

endmodule
